/* src/nd_rdnss_option_parser_defines.svh */
// ----------------------------------------------------------------------------
// nd_rdnss_option_parser_defines
// Assertion macros used by the RDNSS option parser top level.
// ----------------------------------------------------------------------------
`ifndef ND_RDNSS_OPTION_PARSER_DEFINES_SVH
`define ND_RDNSS_OPTION_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while reset is released.
`define ND_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define ND_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ND_ASSERT(lbl, clk, rstn, prop, msg)
`define ND_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/ndrdnss_pkg.sv */
// ----------------------------------------------------------------------------
// ndrdnss_pkg
// Types and constants of the neighbor-discovery RDNSS option parser.
// ----------------------------------------------------------------------------
package ndrdnss_pkg;

    localparam int UNIT_W    = 64;
    localparam int UNITS_W   = 14;
    localparam int TIME_W    = 32;
    localparam int EXPIRY_W  = 33;
    localparam int SERVERS_W = 13;
    localparam int OPT_W     = 8;

    localparam logic [UNITS_W-1:0] MAX_MESSAGE_UNITS = 14'd8192;
    localparam logic [OPT_W-1:0]   RDNSS_TYPE        = 8'd25;
    localparam logic [OPT_W-1:0]   RDNSS_MIN_LEN     = 8'd3;

    // Stream packing: tdata = unit_data, units_in_message, now_seconds.
    localparam int S_DATA_BITS = UNIT_W + UNITS_W + TIME_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int S_USER_W    = 2;
    // Result packing: upper, lower, lifetime, expiry, servers_found.
    localparam int M_DATA_BITS = 2 * UNIT_W + TIME_W + EXPIRY_W + SERVERS_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_USER_W    = 1;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_WALK   = 6'b000010,
        PH_ADDR   = 6'b000100,
        PH_SKIP   = 6'b001000,
        PH_STOP   = 6'b010000,
        PH_IGNORE = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [UNITS_W-1:0]     msg_left;
        logic [OPT_W-1:0]       opt_left;
        logic [TIME_W-1:0]      lifetime;
        logic [UNIT_W-1:0]      upper_half;
        logic                   upper_held;
        logic [SERVERS_W-1:0]   servers;
    } parser_state_t;

    typedef struct packed {
        logic [UNIT_W-1:0]      unit_data;
        logic                   first_unit;
        logic                   last_unit;
        logic                   header_ok;
        logic [UNITS_W-1:0]     units_in_message;
        logic [TIME_W-1:0]      now_seconds;
    } unit_item_t;

    typedef struct packed {
        logic                   has_result;
        logic                   address_valid;
        logic [UNIT_W-1:0]      address_upper;
        logic [UNIT_W-1:0]      address_lower;
        logic [TIME_W-1:0]      lifetime_seconds;
        logic [EXPIRY_W-1:0]    expiry_seconds;
        logic                   end_of_message;
        logic [SERVERS_W-1:0]   servers_found;
    } parse_result_t;

endpackage

/* src/ndrdnss_step.sv */
// ----------------------------------------------------------------------------
// ndrdnss_step
// One parsing step: next parser state and the result for one option unit.
// ----------------------------------------------------------------------------
module ndrdnss_step (
    input  ndrdnss_pkg::parser_state_t cur,
    input  ndrdnss_pkg::unit_item_t    item,
    output ndrdnss_pkg::parser_state_t nxt,
    output ndrdnss_pkg::parse_result_t res
);
    import ndrdnss_pkg::*;

    logic [OPT_W-1:0]   opt_type;
    logic [OPT_W-1:0]   opt_len;
    logic [OPT_W-1:0]   opt_dec;
    logic [UNITS_W-1:0] msg_dec;
    logic               emit;
    logic               ignore_unit;
    parser_state_t      st;

    assign opt_type = item.unit_data[UNIT_W-1 -: OPT_W];
    assign opt_len  = item.unit_data[UNIT_W-OPT_W-1 -: OPT_W];

    always_comb
    begin
        st          = cur;
        emit        = 1'b0;
        ignore_unit = 1'b0;
        opt_dec     = '0;
        msg_dec     = '0;
        res         = '0;

        if (item.first_unit)
        begin
            st = '{phase: PH_IGNORE, msg_left: '0, opt_left: '0, lifetime: '0,
                   upper_half: '0, upper_held: 1'b0, servers: '0};
            if (item.header_ok)
            begin
                st.phase    = PH_WALK;
                st.msg_left = (item.units_in_message > MAX_MESSAGE_UNITS) ?
                              MAX_MESSAGE_UNITS : item.units_in_message;
            end
        end
        else if (cur.phase == PH_IDLE)
        begin
            ignore_unit = 1'b1;
        end

        opt_dec = st.opt_left - 1'b1;
        msg_dec = st.msg_left - 1'b1;

        if (!ignore_unit)
        begin
            unique case (st.phase)
                PH_WALK:
                begin
                    if (st.msg_left == '0 || opt_len == '0 ||
                        {{(UNITS_W-OPT_W){1'b0}}, opt_len} > st.msg_left)
                    begin
                        st.phase = PH_STOP;
                    end
                    else
                    begin
                        st.msg_left = msg_dec;
                        st.opt_left = opt_len - 1'b1;
                        if (opt_type == RDNSS_TYPE && opt_len >= RDNSS_MIN_LEN && opt_len[0])
                        begin
                            st.lifetime   = item.unit_data[TIME_W-1:0];
                            st.upper_held = 1'b0;
                            st.phase      = PH_ADDR;
                        end
                        else if (opt_len != 8'd1)
                        begin
                            st.phase = PH_SKIP;
                        end
                    end
                end
                PH_ADDR:
                begin
                    st.msg_left = msg_dec;
                    st.opt_left = opt_dec;
                    if (!st.upper_held)
                    begin
                        st.upper_half = item.unit_data;
                        st.upper_held = 1'b1;
                    end
                    else
                    begin
                        st.upper_held = 1'b0;
                        st.servers    = st.servers + 1'b1;
                        emit          = 1'b1;
                    end
                    if (opt_dec == '0)
                    begin
                        st.phase = PH_WALK;
                    end
                end
                PH_SKIP:
                begin
                    st.msg_left = msg_dec;
                    st.opt_left = opt_dec;
                    if (opt_dec == '0)
                    begin
                        st.phase = PH_WALK;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // A message that failed the header check ends without a result.
        if (!ignore_unit && !(item.last_unit && st.phase == PH_IGNORE))
        begin
            res.has_result     = emit || item.last_unit;
            res.address_valid  = emit;
            res.end_of_message = item.last_unit;
            res.servers_found  = st.servers;
            if (emit)
            begin
                res.address_upper    = st.upper_half;
                res.address_lower    = item.unit_data;
                res.lifetime_seconds = st.lifetime;
                res.expiry_seconds   = {1'b0, item.now_seconds} + {1'b0, st.lifetime};
            end
        end

        if (!ignore_unit && item.last_unit)
        begin
            st = '{phase: PH_IDLE, msg_left: '0, opt_left: '0, lifetime: '0,
                   upper_half: '0, upper_held: 1'b0, servers: '0};
        end

        nxt = st;
    end

endmodule

/* src/nd_rdnss_option_parser.sv */
// ----------------------------------------------------------------------------
// nd_rdnss_option_parser
// Router advertisement option walker that extracts RDNSS server addresses.
// ----------------------------------------------------------------------------
// Option units of a router advertisement enter on the s_ stream, one 8-octet
// unit per item, marked by tuser (first unit, header check) and tlast (final
// unit). Every RDNSS address that completes leaves on the m_ stream with its
// lifetime and expiry; the final unit of a message that passed the header
// check always gives one item, with address_valid low if no address
// completes on it. Other units give no item.
// An accepted unit is registered, then decoded by one step of combinational
// logic that updates the parser state and loads the result register, from
// which its result is offered on m_. The block takes one unit per cycle for
// as long as the result register drains; that single result register sets
// the rate.
// When the receiver stalls, the result is held and the input register keeps
// at most one further unit; s_tready then falls until m_tready returns.
// Reset clears both registers and returns the parser to idle, awaiting the
// first unit of a message.
// ----------------------------------------------------------------------------
`include "nd_rdnss_option_parser_defines.svh"

module nd_rdnss_option_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // unit_data, units_in_message, now_seconds, zero fill
    input  logic [ndrdnss_pkg::S_DATA_W-1:0] s_tdata,
    // first_unit, header_ok
    input  logic [ndrdnss_pkg::S_USER_W-1:0] s_tuser,
    // last_unit
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // address_upper, address_lower, lifetime_seconds, expiry_seconds,
    // servers_found, zero fill
    output logic [ndrdnss_pkg::M_DATA_W-1:0] m_tdata,
    // address_valid
    output logic [ndrdnss_pkg::M_USER_W-1:0] m_tuser,
    // end_of_message
    output logic                              m_tlast
);
    import ndrdnss_pkg::*;

    logic          in_valid_reg;
    logic          in_valid_next;
    unit_item_t    in_item_reg;
    unit_item_t    in_item_next;
    parser_state_t state_reg;
    parser_state_t state_next;
    parse_result_t step_res;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic          out_user_reg;
    logic          out_user_next;
    logic          out_last_reg;
    logic          out_last_next;
    logic          in_take;
    logic          out_free;
    logic          advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_item_next.unit_data        = s_tdata[UNIT_W-1:0];
        in_item_next.units_in_message = s_tdata[UNIT_W +: UNITS_W];
        in_item_next.now_seconds      = s_tdata[UNIT_W+UNITS_W +: TIME_W];
        in_item_next.first_unit       = s_tuser[0];
        in_item_next.header_ok        = s_tuser[1];
        in_item_next.last_unit        = s_tlast;
    end

    assign in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    ndrdnss_step u_step (
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (advance && step_res.has_result)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{(M_DATA_W-M_DATA_BITS){1'b0}},
                              step_res.servers_found,
                              step_res.expiry_seconds,
                              step_res.lifetime_seconds,
                              step_res.address_lower,
                              step_res.address_upper};
            out_user_next  = step_res.address_valid;
            out_last_next  = step_res.end_of_message;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, msg_left: '0, opt_left: '0, lifetime: '0,
                               upper_half: '0, upper_held: 1'b0, servers: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item_next;
        end
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;
    assign m_tlast    = out_last_reg;

    // A result without an address only ever closes a message.
    `ND_ASSERT(a_empty_result_is_end, clk, rst_n, m_tvalid && !m_tuser[0] |-> m_tlast, "result without address is not end of message")
    `ND_ASSERT(a_empty_result_zero_life, clk, rst_n, m_tvalid && !m_tuser[0] |-> m_tdata[2*UNIT_W +: TIME_W] == '0, "result without address carries a lifetime")
    `ND_ASSERT(a_last_returns_idle, clk, rst_n, advance && in_item_reg.last_unit |=> state_reg.phase == PH_IDLE, "parser not idle after final unit")
    `ND_ASSERT(a_full_blocks_input, clk, rst_n, in_valid_reg && out_valid_reg && !m_tready |-> !s_tready, "input taken while both registers are full")
    `ND_ASSERT_ALWAYS(a_reset_no_result, clk, !rst_n |=> !m_tvalid && !in_valid_reg, "item present after a reset edge")

endmodule
